/* design/range_max_query_with_update_macros.svh */
`ifndef RANGE_MAX_QUERY_WITH_UPDATE_MACROS_SVH
`define RANGE_MAX_QUERY_WITH_UPDATE_MACROS_SVH

// same-cycle implication
`define RMQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/rmq_pkg.sv */
`default_nettype none
package rmq_pkg;

   localparam int RMQ_DEPTH = 1024;
   localparam int RMQ_CELLS = 32;

   localparam int VAL_W = 32;
   localparam int IDX_W = 10;
   localparam int CFG_W = 11;

   localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 11'd1024;

   localparam logic ACT_UPDATE = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_WRITE,
      ST_SWEEP,
      ST_REDUCE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic wipe;
      logic write;
      logic read;
      logic restart;
   } cell_ctl_type;

   typedef struct packed {
      logic                    found;
      logic signed [VAL_W-1:0] value;
   } carry_type;

endpackage
`default_nettype wire

/* design/rmq_cell.sv */
`default_nettype none
module rmq_cell
   import rmq_pkg::*;
#(
   parameter int DEPTH      = RMQ_DEPTH,
   parameter int CELLS      = RMQ_CELLS,
   parameter int CELL_INDEX = 0,
   localparam int SEG       = (DEPTH + CELLS - 1) / CELLS,
   localparam int AW        = (SEG > 1) ? $clog2(SEG) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cell_ctl_type            ctl,
   input  wire logic [AW-1:0]           addr,
   input  wire logic [IDX_W-1:0]        first_index,
   input  wire logic [IDX_W-1:0]        last_index,
   input  wire logic signed [VAL_W-1:0] store_value,
   input  wire carry_type               carry_in,
   output carry_type                    carry_out
);

   localparam int SPAN = CELLS * SEG;
   localparam int GW   = ($clog2(SPAN + 1) > IDX_W) ? $clog2(SPAN + 1) : IDX_W + 1;
   localparam int BASE = CELL_INDEX * SEG;

   logic signed [VAL_W-1:0] mem_ff [SEG];
   logic signed [VAL_W-1:0] rd_ff;
   logic                    hit_ff, hit_in;
   logic                    found_ff, found_in;
   logic signed [VAL_W-1:0] best_ff, best_in;
   carry_type               carry_ff, carry_in_sel;

   logic [GW-1:0] gidx, first_ext, last_ext;
   logic          wr_hit;
   logic [AW-1:0] waddr;
   logic          take;

   assign gidx      = GW'(BASE) + GW'(addr);
   assign first_ext = GW'(first_index);
   assign last_ext  = GW'(last_index);
   assign wr_hit    = ctl.write && (first_ext >= GW'(BASE)) && (first_ext < GW'(BASE + SEG));
   assign waddr     = AW'(first_ext - GW'(BASE));
   assign hit_in    = ctl.read && (gidx >= first_ext) && (gidx <= last_ext);

   always_ff @(posedge clock) begin
      if (ctl.wipe) begin
         mem_ff[addr] <= '0;
      end else if (wr_hit) begin
         mem_ff[waddr] <= store_value;
      end
      if (ctl.read) begin
         rd_ff <= mem_ff[addr];
      end
   end

   // local running maximum over this cell's entries
   assign take = hit_ff && (!found_ff || (rd_ff > best_ff));

   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      if (ctl.restart) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         best_in  = rd_ff;
      end
   end

   // merge with the partial result handed in from the left neighbor
   always_comb begin
      carry_in_sel.found = found_ff;
      carry_in_sel.value = best_ff;
      if (carry_in.found && (!found_ff || (carry_in.value > best_ff))) begin
         carry_in_sel = carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff         <= 1'b0;
         found_ff       <= 1'b0;
         carry_ff.found <= 1'b0;
      end else begin
         hit_ff         <= hit_in;
         found_ff       <= found_in;
         carry_ff.found <= carry_in_sel.found;
         carry_ff.value <= carry_in_sel.value;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign carry_out = carry_ff;

endmodule
`default_nettype wire

/* design/rmq_ctrl.sv */
`default_nettype none
`include "range_max_query_with_update_macros.svh"
module rmq_ctrl
   import rmq_pkg::*;
#(
   parameter int DEPTH = RMQ_DEPTH,
   parameter int CELLS = RMQ_CELLS,
   localparam int SEG  = (DEPTH + CELLS - 1) / CELLS,
   localparam int AW   = (SEG > 1) ? $clog2(SEG) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_action,
   input  wire logic [IDX_W-1:0]        req_first_index,
   input  wire logic [IDX_W-1:0]        req_last_index,
   input  wire logic signed [VAL_W-1:0] req_store_value,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CFG_W-1:0]        csr_data,
   output cell_ctl_type                 ctl,
   output logic [AW-1:0]                addr,
   output logic [IDX_W-1:0]             first_index,
   output logic [IDX_W-1:0]             last_index,
   output logic signed [VAL_W-1:0]      store_value,
   input  wire carry_type               tail,
   output logic                         rsp_valid,
   output logic signed [VAL_W-1:0]      rsp_max_value,
   output logic                         rsp_range_error
);

   localparam int CNT_MAX = (SEG > CELLS + 1) ? SEG : CELLS + 1;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   localparam int CW      = ($clog2(DEPTH + 1) > CFG_W) ? $clog2(DEPTH + 1) : CFG_W;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CFG_W-1:0]        count_ff;
   logic [IDX_W-1:0]        first_ff, last_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic                    bad_ff;

   logic [CW-1:0] eff_count;
   logic          accept;
   logic          first_bad, last_bad, bad_now;

   assign eff_count = (CW'(count_ff) < CW'(DEPTH)) ? CW'(count_ff) : CW'(DEPTH);
   assign accept    = start && (state_ff == ST_IDLE);
   assign first_bad = CW'(req_first_index) >= eff_count;
   assign last_bad  = CW'(req_last_index) >= eff_count;
   assign bad_now   = (req_action == ACT_UPDATE) ? first_bad :
                      (first_bad || last_bad || (req_first_index > req_last_index));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               if (req_action == ACT_UPDATE) begin
                  state_in = ST_WRITE;
               end else if (bad_now) begin
                  state_in = ST_RESPOND;
               end else begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SEG - 1)) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SEG - 1)) begin
               state_in = ST_REDUCE;
               cnt_in   = '0;
            end
         end
         ST_REDUCE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CELLS)) begin
               state_in = ST_RESPOND;
               cnt_in   = '0;
            end
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            ctl.restart = 1'b1;
         end
         ST_CLEAR: begin
            ctl.wipe = 1'b1;
         end
         ST_WRITE: begin
            ctl.write = !bad_ff;
         end
         ST_SWEEP: begin
            ctl.read = 1'b1;
         end
         ST_REDUCE: begin
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         count_ff <= CFG_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_valid) begin
            count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff <= req_first_index;
         last_ff  <= req_last_index;
         value_ff <= req_store_value;
         bad_ff   <= bad_now;
      end
   end

   assign csr_ready       = 1'b1;
   assign addr            = AW'(cnt_ff);
   assign first_index     = first_ff;
   assign last_index      = last_ff;
   assign store_value     = value_ff;
   assign rsp_range_error = bad_ff;
   assign rsp_max_value   = bad_ff ? '0 : tail.value;

   `RMQ_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   `RMQ_ASSERT_NOW(a_result_found, clock, reset, rsp_valid && !rsp_range_error, tail.found, "no entry reached the tail")
   `RMQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy, "busy not raised after item")

endmodule
`default_nettype wire

/* design/range_max_query_with_update.sv */
// channel   ports                                      handshake
// request   req_action req_first_index req_last_index   start and not busy
//           req_store_value
// result    rsp_max_value rsp_range_error               rsp_valid, one cycle
// config    csr_data (item count)                       csr_valid and csr_ready
//
// an update holds busy after acceptance while it writes its entry
// a query sweeps every cell's bank in parallel, one entry per cycle, then
// passes the partial maximum down the row of cells and raises the result
// strobe; busy stays high from acceptance until that strobe
// a query with a bad range goes straight to the result, skipping the sweep
// synchronous reset starts a clearing pass over every bank entry, busy meanwhile
// the result strobe lasts one cycle and cannot be held off
`default_nettype none
module range_max_query_with_update
   import rmq_pkg::*;
#(
   parameter int DEPTH = RMQ_DEPTH,
   parameter int CELLS = RMQ_CELLS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_action,
   input  wire logic [IDX_W-1:0]        req_first_index,
   input  wire logic [IDX_W-1:0]        req_last_index,
   input  wire logic signed [VAL_W-1:0] req_store_value,
   output logic                         rsp_valid,
   output logic signed [VAL_W-1:0]      rsp_max_value,
   output logic                         rsp_range_error,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CFG_W-1:0]        csr_data
);

   localparam int SEG = (DEPTH + CELLS - 1) / CELLS;
   localparam int AW  = (SEG > 1) ? $clog2(SEG) : 1;

   cell_ctl_type            ctl;
   logic [AW-1:0]           addr;
   logic [IDX_W-1:0]        first_index, last_index;
   logic signed [VAL_W-1:0] store_value;
   carry_type               chain [CELLS+1];

   assign chain[0] = '0;

   rmq_ctrl #(
      .DEPTH (DEPTH),
      .CELLS (CELLS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_store_value (req_store_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .ctl             (ctl),
      .addr            (addr),
      .first_index     (first_index),
      .last_index      (last_index),
      .store_value     (store_value),
      .tail            (chain[CELLS]),
      .rsp_valid       (rsp_valid),
      .rsp_max_value   (rsp_max_value),
      .rsp_range_error (rsp_range_error)
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      rmq_cell #(
         .DEPTH      (DEPTH),
         .CELLS      (CELLS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .addr        (addr),
         .first_index (first_index),
         .last_index  (last_index),
         .store_value (store_value),
         .carry_in    (chain[i]),
         .carry_out   (chain[i+1])
      );
   end

endmodule
`default_nettype wire
